@@ rtl/ddsc_pkg.sv @@
`timescale 1ns / 1ps

package ddsc_pkg;

  localparam int OUTER_DIVIDE_DEF = 2;
  localparam int DUTY_MAX         = 10000;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED_P    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_I    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_D    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_KP   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_KD   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 4'd7;

  localparam logic [15:0]        SPEED_P_RST    = 16'd1664;
  localparam logic [15:0]        SPEED_I_RST    = 16'd0;
  localparam logic [15:0]        SPEED_D_RST    = 16'd0;
  localparam logic [15:0]        STEER_KP_RST   = 16'd2622;
  localparam logic [15:0]        STEER_KD_RST   = 16'd5190;
  localparam logic [14:0]        OUT_MAX_RST    = 15'd4000;
  localparam logic signed [15:0] OUT_MIN_RST    = 16'sd50;
  localparam logic [10:0]        BASE_SPEED_RST = 11'd130;

  // steering constants
  localparam logic [8:0]  DEADBAND      = 9'd2;
  localparam logic [8:0]  SOFT_ZONE     = 9'd10;
  localparam logic [10:0] BASE_FLOOR    = 11'd120;
  localparam logic [10:0] TARGET_MAX    = 11'd1500;
  localparam logic [11:0] TURN_LIMIT_Q5 = 12'd2500;
  localparam logic [15:0] RECIP_5       = 16'd52429;

  typedef struct packed {
    logic signed [8:0]  line_offset;
    logic signed [15:0] left_count;
    logic signed [15:0] right_count;
    logic               stop;
  } item_t;

  typedef struct packed {
    logic [13:0] left_duty;
    logic        left_reverse;
    logic [13:0] right_duty;
    logic        right_reverse;
    logic [10:0] left_target;
    logic [10:0] right_target;
  } result_t;

  typedef struct packed {
    logic [15:0] kp;
    logic [15:0] kd;
  } steer_cfg_t;

  typedef struct packed {
    logic [15:0]        p;
    logic [15:0]        i;
    logic [15:0]        d;
    logic [14:0]        out_max;
    logic signed [15:0] out_min;
  } wheel_cfg_t;

endpackage

@@ rtl/differential_drive_speed_control_unit.sv @@
`timescale 1ns / 1ps
// flow: one item at a time; the next beat is taken once the result is registered, which waits
//   while an earlier result is still unaccepted; steering ticks also run the steering unit
//   before the wheels; the pace is set by the single shared multiplier in each wheel lane
//   (three products) and in the steering unit (three products, including the divide by 1280)
// reset: synchronous, active high; registers return to their defaults, all loop state
//   and the tick phase clear to zero, no result pending

module differential_drive_speed_control_unit #(
  parameter int OUTER_DIVIDE = ddsc_pkg::OUTER_DIVIDE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  ddsc_pkg::item_t                item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output ddsc_pkg::result_t              result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ddsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ddsc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ddsc_pkg::*;

  localparam int PHASE_W  = (OUTER_DIVIDE > 1) ? $clog2(OUTER_DIVIDE) : 1;
  localparam int PHASE_CW = PHASE_W + 1;

  typedef enum logic [2:0] {
    T_IDLE, T_LAUNCH, T_STEER, T_WHEEL, T_OUT
  } state_t;

  state_t state;

  steer_cfg_t steer_cfg;
  wheel_cfg_t wheel_cfg;
  logic [10:0] base_speed;

  logic [PHASE_W-1:0]  phase;
  logic [PHASE_CW-1:0] phase_inc;
  logic                wrap;

  logic signed [8:0]  offset_q;
  logic signed [16:0] lcount_q;
  logic signed [16:0] rcount_q;
  logic [10:0]        goal_q;
  logic               do_steer;

  logic steer_start;
  logic steer_done;
  logic wheel_start;
  logic left_done;
  logic right_done;
  logic [10:0] left_target;
  logic [10:0] right_target;
  logic signed [15:0] left_drive;
  logic signed [15:0] right_drive;

  function automatic logic [13:0] duty_of(input logic signed [15:0] drv);
    logic [16:0] mag;
    mag = drv[15] ? 17'(-17'(drv)) : 17'(drv);
    if (mag > 17'(DUTY_MAX)) begin
      mag = 17'(DUTY_MAX);
    end
    return mag[13:0];
  endfunction

  assign cfg_ready  = 1'b1;
  assign item_ready = (state == T_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_cfg.p       <= SPEED_P_RST;
      wheel_cfg.i       <= SPEED_I_RST;
      wheel_cfg.d       <= SPEED_D_RST;
      steer_cfg.kp      <= STEER_KP_RST;
      steer_cfg.kd      <= STEER_KD_RST;
      wheel_cfg.out_max <= OUT_MAX_RST;
      wheel_cfg.out_min <= OUT_MIN_RST;
      base_speed        <= BASE_SPEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SPEED_P:    wheel_cfg.p       <= cfg_data;
        REG_SPEED_I:    wheel_cfg.i       <= cfg_data;
        REG_SPEED_D:    wheel_cfg.d       <= cfg_data;
        REG_STEER_KP:   steer_cfg.kp      <= cfg_data;
        REG_STEER_KD:   steer_cfg.kd      <= cfg_data;
        REG_OUT_MAX:    wheel_cfg.out_max <= cfg_data[14:0];
        REG_OUT_MIN:    wheel_cfg.out_min <= $signed(cfg_data);
        REG_BASE_SPEED: base_speed        <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  assign phase_inc = PHASE_CW'(phase) + PHASE_CW'(1);
  assign wrap      = phase_inc >= PHASE_CW'(OUTER_DIVIDE);

  always_comb begin
    steer_start = 1'b0;
    wheel_start = 1'b0;
    case (state)
      T_LAUNCH: begin
        steer_start = do_steer;
        wheel_start = !do_steer;
      end
      T_STEER: wheel_start = steer_done;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_IDLE;
      phase        <= '0;
      do_steer     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && state != T_OUT) begin
        result_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (item_valid) begin
            offset_q <= item.line_offset;
            lcount_q <= -17'(item.left_count);
            rcount_q <= 17'(item.right_count);
            goal_q   <= item.stop ? 11'd0 : base_speed;
            do_steer <= wrap;
            phase    <= wrap ? '0 : phase_inc[PHASE_W-1:0];
            state    <= T_LAUNCH;
          end
        end
        T_LAUNCH: state <= do_steer ? T_STEER : T_WHEEL;
        T_STEER: begin
          if (steer_done) begin
            state <= T_WHEEL;
          end
        end
        T_WHEEL: begin
          if (left_done && right_done) begin
            state <= T_OUT;
          end
        end
        T_OUT: begin
          // merge the two lanes once the previous beat has gone
          if (!result_valid || result_ready) begin
            result.left_duty     <= duty_of(left_drive);
            result.left_reverse  <= left_drive[15];
            result.right_duty    <= duty_of(right_drive);
            result.right_reverse <= right_drive[15];
            result.left_target   <= left_target;
            result.right_target  <= right_target;
            result_valid         <= 1'b1;
            state                <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  ddsc_steer u_steer (
    .clk          (clk),
    .rst          (rst),
    .start        (steer_start),
    .line_offset  (offset_q),
    .goal         (goal_q),
    .cfg          (steer_cfg),
    .done         (steer_done),
    .left_target  (left_target),
    .right_target (right_target)
  );

  ddsc_wheel u_wheel_left (
    .clk    (clk),
    .rst    (rst),
    .start  (wheel_start),
    .target (left_target),
    .count  (lcount_q),
    .cfg    (wheel_cfg),
    .done   (left_done),
    .drive  (left_drive)
  );

  ddsc_wheel u_wheel_right (
    .clk    (clk),
    .rst    (rst),
    .start  (wheel_start),
    .target (right_target),
    .count  (rcount_q),
    .cfg    (wheel_cfg),
    .done   (right_done),
    .drive  (right_drive)
  );

endmodule

@@ rtl/ddsc_steer.sv @@
`timescale 1ns / 1ps

module ddsc_steer (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [8:0]   line_offset,
  input  logic [10:0]         goal,
  input  ddsc_pkg::steer_cfg_t cfg,
  output logic                done,
  output logic [10:0]         left_target,
  output logic [10:0]         right_target
);
  import ddsc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_P, S_MUL_D, S_SUM, S_ABS, S_DIV, S_TGT
  } state_t;

  state_t state;

  logic signed [8:0]  last_err;
  logic signed [11:0] em;
  logic signed [12:0] de5;
  logic [10:0]        base;
  logic signed [29:0] prod;
  logic signed [30:0] acc;
  logic [11:0]        amag;
  logic               neg;

  logic [8:0]         ae_raw;
  logic               dead;
  logic signed [8:0]  e;
  logic [8:0]         ae;
  logic signed [11:0] e12;
  logic signed [12:0] de13;
  logic [11:0]        ae7;
  logic signed [12:0] base_raw;
  logic [15:0]        mul_a;
  logic signed [12:0] mul_b;
  logic signed [29:0] mul_w;
  logic [30:0]        acc_mag;
  logic [22:0]        acc_sh;
  logic signed [9:0]  turn;
  logic signed [12:0] sum_l;
  logic signed [12:0] sum_r;

  function automatic logic [10:0] clamp_target(input logic signed [12:0] v);
    if (v < 13'sd0) begin
      return 11'd0;
    end else if (v > $signed({2'b00, TARGET_MAX})) begin
      return TARGET_MAX;
    end else begin
      return v[10:0];
    end
  endfunction

  always_comb begin
    ae_raw   = line_offset[8] ? 9'(-line_offset) : 9'(line_offset);
    dead     = ae_raw < DEADBAND;
    e        = dead ? 9'sd0 : line_offset;
    ae       = dead ? 9'd0 : ae_raw;
    e12      = 12'(e);
    em       = (ae < SOFT_ZONE) ? (e12 + (e12 <<< 1)) : (e12 + (e12 <<< 2));
    de13     = 13'(e) - 13'(last_err);
    ae7      = {ae, 3'b000} - {3'b000, ae};
    base_raw = $signed({2'b00, goal}) - $signed({2'b00, ae7[11:1]});
  end

  always_comb begin
    case (state)
      S_MUL_P: begin
        mul_a = cfg.kp;
        mul_b = 13'(em);
      end
      S_MUL_D: begin
        mul_a = cfg.kd;
        mul_b = de5;
      end
      default: begin
        mul_a = RECIP_5;
        mul_b = $signed({1'b0, amag});
      end
    endcase
    mul_w = $signed({1'b0, mul_a}) * mul_b;
  end

  always_comb begin
    acc_mag = acc[30] ? 31'(-acc) : 31'(acc);
    acc_sh  = acc_mag[30:8];
    turn    = neg ? -$signed({1'b0, prod[26:18]}) : $signed({1'b0, prod[26:18]});
    sum_l   = $signed({2'b00, base}) + 13'(turn);
    sum_r   = $signed({2'b00, base}) - 13'(turn);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      last_err     <= '0;
      left_target  <= '0;
      right_target <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            de5      <= de13 + (de13 <<< 2);
            base     <= (base_raw < $signed({2'b00, BASE_FLOOR})) ? BASE_FLOOR
                                                                  : base_raw[10:0];
            last_err <= e;
            state    <= S_MUL_P;
          end
        end
        S_MUL_P: begin
          prod  <= mul_w;
          state <= S_MUL_D;
        end
        S_MUL_D: begin
          acc   <= 31'(prod);
          prod  <= mul_w;
          state <= S_SUM;
        end
        S_SUM: begin
          acc   <= acc + 31'(prod);
          state <= S_ABS;
        end
        S_ABS: begin
          neg   <= acc[30];
          amag  <= (acc_sh >= 23'(TURN_LIMIT_Q5)) ? TURN_LIMIT_Q5 : acc_sh[11:0];
          state <= S_DIV;
        end
        S_DIV: begin
          prod  <= mul_w;
          state <= S_TGT;
        end
        S_TGT: begin
          left_target  <= clamp_target(sum_l);
          right_target <= clamp_target(sum_r);
          done         <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/ddsc_wheel.sv @@
`timescale 1ns / 1ps

module ddsc_wheel (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [10:0]          target,
  input  logic signed [16:0]   count,
  input  ddsc_pkg::wheel_cfg_t cfg,
  output logic                 done,
  output logic signed [15:0]   drive
);
  import ddsc_pkg::*;

  typedef enum logic [2:0] {
    W_IDLE, W_MUL_P, W_MUL_I, W_MUL_D, W_SUM, W_FIN
  } state_t;

  state_t state;

  logic signed [16:0] err_last;
  logic signed [16:0] err_prev;
  logic signed [16:0] err;
  logic signed [17:0] d1;
  logic signed [18:0] d2;
  logic               frozen;
  logic signed [35:0] prod;
  logic signed [37:0] acc;

  logic signed [17:0] err_w;
  logic signed [16:0] err_n;
  logic signed [16:0] drv17;
  logic signed [16:0] lim17;
  logic               err_pos;
  logic               frozen_w;
  logic [15:0]        mul_a;
  logic signed [18:0] mul_b;
  logic signed [35:0] mul_w;
  logic signed [37:0] step;
  logic signed [37:0] v;

  always_comb begin
    err_w    = $signed({7'b0, target}) - 18'(count);
    err_n    = err_w[16:0];
    drv17    = 17'(drive);
    lim17    = $signed({2'b00, cfg.out_max});
    err_pos  = !err_n[16] && (err_n != 17'sd0);
    frozen_w = ((drv17 >= lim17) && err_pos) || ((drv17 <= -lim17) && err_n[16]);
  end

  always_comb begin
    case (state)
      W_MUL_P: begin
        mul_a = cfg.p;
        mul_b = 19'(d1);
      end
      W_MUL_I: begin
        mul_a = frozen ? 16'd0 : cfg.i;
        mul_b = 19'(err);
      end
      default: begin
        mul_a = cfg.d;
        mul_b = d2;
      end
    endcase
    mul_w = $signed({1'b0, mul_a}) * mul_b;
  end

  // divide by 256 truncating toward zero
  always_comb begin
    step = acc[37] ? ((acc + 38'sd255) >>> 8) : (acc >>> 8);
    v    = 38'(drive) + step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= W_IDLE;
      done     <= 1'b0;
      drive    <= '0;
      err_last <= '0;
      err_prev <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        W_IDLE: begin
          if (start) begin
            err      <= err_n;
            d1       <= 18'(err_n) - 18'(err_last);
            d2       <= 19'(err_n) - (19'(err_last) <<< 1) + 19'(err_prev);
            frozen   <= frozen_w;
            err_prev <= err_last;
            err_last <= err_n;
            state    <= W_MUL_P;
          end
        end
        W_MUL_P: begin
          prod  <= mul_w;
          state <= W_MUL_I;
        end
        W_MUL_I: begin
          acc   <= 38'(prod);
          prod  <= mul_w;
          state <= W_MUL_D;
        end
        W_MUL_D: begin
          acc   <= acc + 38'(prod);
          prod  <= mul_w;
          state <= W_SUM;
        end
        W_SUM: begin
          acc   <= acc + 38'(prod);
          state <= W_FIN;
        end
        W_FIN: begin
          if (v < 38'(cfg.out_min)) begin
            drive <= cfg.out_min;
          end else if (v > $signed({23'b0, cfg.out_max})) begin
            drive <= $signed({1'b0, cfg.out_max});
          end else begin
            drive <= v[15:0];
          end
          done  <= 1'b1;
          state <= W_IDLE;
        end
        default: state <= W_IDLE;
      endcase
    end
  end

endmodule
